>>> rtl/ula_pkg.sv
`timescale 1ns / 1ps

package ula_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TERM_LEN   = 2'd0;
    localparam logic [1:0] CFG_TERM_BYTES = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN    = 2'd2;

    // configuration reset values
    localparam logic [2:0]  TERM_LEN_RST   = 3'd2;
    localparam logic [31:0] TERM_BYTES_RST = 32'h0000_0D0A;
    localparam logic [5:0]  MAX_LEN_RST    = 6'd63;

    // terminator length limits
    localparam logic [2:0] TERM_LEN_MIN = 3'd1;
    localparam logic [2:0] TERM_LEN_MAX = 3'd4;

    // one completed line handed from the front to the back
    typedef struct packed {
        logic [5:0] n;      // bytes to emit, zero gives a single filler word
        logic       empty;  // no bytes before the terminator
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_OUT
    } t_back_state;

endpackage

>>> rtl/uart_line_assembler_unit.sv
`timescale 1ns / 1ps
// Line assembler for a received byte stream.
// rx channel (i_rx_valid/o_rx_ready/i_rx_byte): one received byte per word.
//   Zero bytes are dropped. Other bytes fill a line store; when the tail
//   matches the terminator the line (without terminator) is sent out.
// line channel (o_line_valid/i_line_ready): one line byte per word, o_last on
//   the final one; an empty line gives one word with o_empty_line set.
//   Lines longer than max_line_len are cut; a store that fills is dropped.
// cfg channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data): always ready;
//   index 0 term_len, 1 term_bytes, 2 max_line_len. Write only when idle.
// Flow: a terminated line is queued and picked up in the next cycle; each
//   line byte then takes a store read, then an output word. An empty or
//   cut-to-nothing line gives a single word. The single line store port
//   pair is shared, so rx is held off while a line drains.
// A stalled receiver just holds the current output word; nothing is lost.
// Reset: synchronous, active low; clears fill, queue and sequencer and loads
//   the register defaults (CR LF terminator, 63-byte limit).
module uart_line_assembler_unit
    import ula_pkg::*;
#(
    parameter int BUF_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_line_valid,
    input  logic        i_line_ready,
    output logic [7:0]  o_line_byte,
    output logic        o_last,
    output logic        o_empty_line,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(BUF_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          push;
    logic          pop;
    t_job          push_job;
    t_job          head_job;
    logic          q_empty;
    logic          back_idle;

    ula_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_job       (push_job),
        .i_q_empty   (q_empty),
        .i_back_idle (back_idle)
    );

    ula_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    ula_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_q_empty    (q_empty),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_idle       (back_idle),
        .o_line_valid (o_line_valid),
        .i_line_ready (i_line_ready),
        .o_line_byte  (o_line_byte),
        .o_last       (o_last),
        .o_empty_line (o_empty_line)
    );

endmodule

>>> rtl/ula_front.sv
`timescale 1ns / 1ps

module ula_front
    import ula_pkg::*;
#(
    parameter int BUF_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // received bytes
    input  logic                         i_rx_valid,
    output logic                         o_rx_ready,
    input  logic [7:0]                   i_rx_byte,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    // line store write port
    output logic                         o_wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] o_wr_addr,
    output logic [7:0]                   o_wr_data,
    // job queue and back status
    output logic                         o_push,
    output t_job                         o_job,
    input  logic                         i_q_empty,
    input  logic                         i_back_idle
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = (AW > 6) ? AW : 6;
    localparam logic [AW-1:0] FULL_FILL = AW'(BUF_DEPTH - 1);

    logic [2:0]    r_term_len;
    logic [31:0]   r_term_bytes;
    logic [5:0]    r_max_len;
    logic [AW-1:0] r_fill;
    logic [31:0]   r_recent;
    logic [AW-1:0] n_fill;
    logic [31:0]   n_recent;

    logic [2:0]    tl;
    logic [AW-1:0] fill_inc;
    logic [31:0]   recent_inc;
    logic [3:0]    hit;
    logic          full;
    logic          match;
    logic [AW-1:0] line_len;
    logic [LW-1:0] line_ext;
    logic [5:0]    emit_n;
    logic          take;

    // the line store is shared with the back, so hold off while a line drains
    assign o_rx_ready  = i_q_empty && i_back_idle;
    assign o_cfg_ready = 1'b1;
    assign take        = i_rx_valid && o_rx_ready && (i_rx_byte != 8'd0);

    // append, then check for a full store or a terminator at the tail
    always_comb begin
        if (r_term_len < TERM_LEN_MIN) begin
            tl = TERM_LEN_MIN;
        end else if (r_term_len > TERM_LEN_MAX) begin
            tl = TERM_LEN_MAX;
        end else begin
            tl = r_term_len;
        end
        fill_inc   = r_fill + 1'b1;
        recent_inc = {r_recent[23:0], i_rx_byte};
        for (int i = 0; i < 4; i++) begin
            hit[i] = (3'(i) >= tl) || (recent_inc[8*i +: 8] == r_term_bytes[8*i +: 8]);
        end
        full     = (fill_inc == FULL_FILL);
        match    = (&hit) && (fill_inc >= AW'(tl));
        line_len = fill_inc - AW'(tl);
        line_ext = LW'(line_len);
        emit_n   = (line_ext < LW'(r_max_len)) ? line_ext[5:0] : r_max_len;

        o_job.n     = emit_n;
        o_job.empty = (line_len == '0);
        o_push      = take && !full && match;
        o_wr_en     = take;
        o_wr_addr   = r_fill;
        o_wr_data   = i_rx_byte;

        n_fill   = r_fill;
        n_recent = r_recent;
        if (take) begin
            if (full || match) begin
                n_fill   = '0;
                n_recent = '0;
            end else begin
                n_fill   = fill_inc;
                n_recent = recent_inc;
            end
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_recent <= '0;
        end else begin
            r_fill   <= n_fill;
            r_recent <= n_recent;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len   <= TERM_LEN_RST;
            r_term_bytes <= TERM_BYTES_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TERM_LEN:   r_term_len   <= i_cfg_data[2:0];
                CFG_TERM_BYTES: r_term_bytes <= i_cfg_data;
                CFG_MAX_LEN:    r_max_len    <= i_cfg_data[5:0];
                default:        ;
            endcase
        end
    end

    // the store is dropped before it can fill up
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FULL_FILL)
        else $error("line fill reached full level");

    // an empty-line job never carries bytes
    a_empty_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.empty) |-> (o_job.n == 6'd0))
        else $error("empty line job with nonzero length");

endmodule

>>> rtl/ula_jobq.sv
`timescale 1ns / 1ps

module ula_jobq
    import ula_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    // two-entry queue of completed lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");

endmodule

>>> rtl/ula_back.sv
`timescale 1ns / 1ps

module ula_back
    import ula_pkg::*;
#(
    parameter int BUF_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // line store write port
    input  logic                         i_wr_en,
    input  logic [$clog2(BUF_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    // job queue
    input  logic                         i_q_empty,
    input  t_job                         i_job,
    output logic                         o_pop,
    output logic                         o_idle,
    // line words out
    output logic                         o_line_valid,
    input  logic                         i_line_ready,
    output logic [7:0]                   o_line_byte,
    output logic                         o_last,
    output logic                         o_empty_line
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = (AW > 6) ? AW : 6;

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;

    t_back_state   r_state;
    t_back_state   n_state;
    logic [LW-1:0] r_idx;
    logic [LW-1:0] n_idx;
    logic [5:0]    r_n;
    logic [5:0]    n_n;
    logic          r_last;
    logic          n_last;
    logic          r_zero;
    logic          n_zero;
    logic          r_empty;
    logic          n_empty;
    logic          rd_en;

    // line store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_last  <= n_last;
        r_zero  <= n_zero;
        r_empty <= n_empty;
    end

    // dump sequencer: one read, then one output word, per line byte; a zero-length job gives one word
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_n     = r_n;
        n_last  = r_last;
        n_zero  = r_zero;
        n_empty = r_empty;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_n   = i_job.n;
                    n_idx = '0;
                    if (i_job.n == 6'd0) begin
                        n_zero  = 1'b1;
                        n_last  = 1'b1;
                        n_empty = i_job.empty;
                        n_state = BK_OUT;
                    end else begin
                        n_zero  = 1'b0;
                        n_empty = 1'b0;
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: begin
                rd_en   = 1'b1;
                n_last  = ((r_idx + 1'b1) == LW'(r_n));
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (i_line_ready) begin
                    if (r_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_idle       = (r_state == BK_IDLE);
    assign o_line_valid = (r_state == BK_OUT);
    assign o_line_byte  = r_zero ? 8'd0 : r_rd_data;
    assign o_last       = r_last;
    assign o_empty_line = r_empty;

    // reads stay inside the line being dumped
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_READ) |-> (r_idx < LW'(r_n)))
        else $error("line store read past line end");

    // the closing word of a line returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_line_valid && i_line_ready && r_last) |=> (r_state == BK_IDLE))
        else $error("sequencer kept running after last word");

endmodule
